>>> src/idalloc_pkg.sv
// Shared types and constants for the slot ID allocator.
// Holds the request/response payload structs, opcode and status codes, and queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package idalloc_pkg;

    // Fixed field widths of the request and response payloads.
    localparam int ID_WIDTH  = 10;
    localparam int TAG_WIDTH = 32;

    // Default sizing of the slot table.
    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int OWNER_WIDTH_DEF = 32;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Width used to compare slot numbers against table sizes up to 65536.
    localparam int WIDE_IDX = 17;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_OTHER  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DENIED = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [ID_WIDTH-1:0]   slot_id;
        logic [TAG_WIDTH-1:0]  owner_tag;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [ID_WIDTH-1:0]   result_id;
        logic [TAG_WIDTH-1:0]  result_owner;
    } rsp_t;

    // Classified operation as it travels from the front end to the back end.
    typedef struct packed {
        opcode_t               op;
        logic                  ranged;
        logic [ID_WIDTH-1:0]   slot_id;
        logic [TAG_WIDTH-1:0]  owner_tag;
    } task_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

>>> src/idalloc_front.sv
// Front end of the slot ID allocator: accepts requests and classifies them.
// Depends on idalloc_pkg; feeds idalloc_queue.
`timescale 1ns / 1ps
`default_nettype none

module idalloc_front #(
    parameter int SLOT_COUNT = idalloc_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire idalloc_pkg::req_t   req,
    input  wire idalloc_pkg::qstat_t qstat,
    output logic                     push,
    output idalloc_pkg::task_t       push_task
);

    logic [idalloc_pkg::WIDE_IDX-1:0] slot_wide;

    // Hold off the requester while the queue has no room.
    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;

    // Decode the operation and check the slot against the table size.
    always_comb
    begin
        slot_wide           = idalloc_pkg::WIDE_IDX'(req.slot_id);
        push_task.op        = req.opcode;
        push_task.ranged    = slot_wide < idalloc_pkg::WIDE_IDX'(SLOT_COUNT);
        push_task.slot_id   = req.slot_id;
        push_task.owner_tag = req.owner_tag;
    end

endmodule

`default_nettype wire

>>> src/idalloc_queue.sv
// Short FIFO of classified operations between the front end and the back end.
// Depends on idalloc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idalloc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire idalloc_pkg::task_t push_task,
    input  wire logic               pop,
    output idalloc_pkg::task_t      head_task,
    output idalloc_pkg::qstat_t     qstat
);

    localparam int DEPTH = idalloc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    idalloc_pkg::task_t entry_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW-1:0]      rd_ptr_next;
    logic [CNTW-1:0]    count_reg;
    logic [CNTW-1:0]    count_next;
    logic               do_push;
    logic               do_pop;

    assign qstat.full      = count_reg == CNTW'(DEPTH);
    assign qstat.not_empty = count_reg != '0;
    assign head_task       = entry_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && qstat.not_empty;

    // Pointer and count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

`default_nettype wire

>>> src/idalloc_back.sv
// Back end of the slot ID allocator: slot memories, free list, high-water count and result register.
// Depends on idalloc_pkg; takes operations from idalloc_queue.
`timescale 1ns / 1ps
`default_nettype none

module idalloc_back #(
    parameter int SLOT_COUNT  = idalloc_pkg::SLOT_COUNT_DEF,
    parameter int OWNER_WIDTH = idalloc_pkg::OWNER_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire idalloc_pkg::task_t  head_task,
    input  wire idalloc_pkg::qstat_t qstat,
    output logic                     pop,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output idalloc_pkg::rsp_t        rsp
);

    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int CW   = $clog2(SLOT_COUNT + 1);
    localparam int WI   = idalloc_pkg::WIDE_IDX;
    localparam int IDW  = idalloc_pkg::ID_WIDTH;
    localparam int TW   = idalloc_pkg::TAG_WIDTH;

    // A free-list link: either the next free slot or the end of the list.
    typedef struct packed {
        logic          last;
        logic [IW-1:0] idx;
    } link_t;

    // Slot memories. Entries may be read before they were written; the high-water and free-list checks mask such reads.
    logic             inuse_mem [SLOT_COUNT];
    logic [OWNER_WIDTH-1:0] owner_mem [SLOT_COUNT];
    link_t            link_mem  [SLOT_COUNT];

    idalloc_pkg::back_state_t state_reg;
    idalloc_pkg::back_state_t state_next;
    idalloc_pkg::task_t       task_reg;
    logic                     rd_inuse_reg;
    logic [OWNER_WIDTH-1:0]   rd_owner_reg;
    link_t                    rd_link_reg;
    logic                     head_valid_reg;
    logic                     head_valid_next;
    logic [IW-1:0]            head_reg;
    logic [IW-1:0]            head_next;
    logic [CW-1:0]            hw_reg;
    logic [CW-1:0]            hw_next;
    logic                     deny_reg;
    idalloc_pkg::rsp_t        rsp_reg;
    idalloc_pkg::rsp_t        rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    logic                     out_free;
    logic                     exec_fire;
    logic [WI-1:0]            slot_wide;
    logic [IW-1:0]            slot_idx;
    logic                     slot_live;
    logic                     hw_avail;
    logic                     alloc_go;
    logic                     alloc_from_list;
    logic [IW-1:0]            alloc_slot;
    logic                     free_go;
    logic [WI-1:0]            grant_wide;
    logic [63:0]              tag_wide;
    logic [63:0]              owner_wide;
    logic                     inuse_we;
    logic [IW-1:0]            inuse_addr;
    logic                     inuse_din;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Sequencer: take an operation, read the memories, then execute it.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        exec_fire  = 1'b0;
        unique case (state_reg)
            idalloc_pkg::BK_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    pop        = 1'b1;
                    state_next = idalloc_pkg::BK_READ;
                end
            end
            idalloc_pkg::BK_READ:
            begin
                state_next = idalloc_pkg::BK_EXEC;
            end
            idalloc_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    exec_fire  = 1'b1;
                    state_next = idalloc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = idalloc_pkg::BK_IDLE;
            end
        endcase
    end

    // Slot index and liveness; slots at or above the high-water mark were never in use.
    always_comb
    begin
        slot_wide = WI'(task_reg.slot_id);
        slot_idx  = slot_wide[IW-1:0];
        slot_live = task_reg.ranged && rd_inuse_reg && (CW'(slot_idx) < hw_reg);
        hw_avail  = hw_reg < CW'(SLOT_COUNT);
        tag_wide  = 64'(task_reg.owner_tag);
        owner_wide = 64'(rd_owner_reg);
    end

    // Operation decision and result formation.
    always_comb
    begin
        alloc_go        = 1'b0;
        alloc_from_list = 1'b0;
        alloc_slot      = head_reg;
        free_go         = 1'b0;
        grant_wide      = WI'(head_reg);
        rsp_next.status       = idalloc_pkg::ST_UNUSED;
        rsp_next.result_id    = task_reg.slot_id;
        rsp_next.result_owner = '0;
        unique case (task_reg.op)
            idalloc_pkg::OP_ALLOC:
            begin
                if (deny_reg)
                begin
                    rsp_next.status = idalloc_pkg::ST_DENIED;
                end
                else if (head_valid_reg)
                begin
                    alloc_go           = 1'b1;
                    alloc_from_list    = 1'b1;
                    alloc_slot         = head_reg;
                    grant_wide         = WI'(head_reg);
                    rsp_next.status    = idalloc_pkg::ST_OK;
                    rsp_next.result_id = grant_wide[IDW-1:0];
                end
                else if (hw_avail)
                begin
                    alloc_go           = 1'b1;
                    alloc_slot         = hw_reg[IW-1:0];
                    grant_wide         = WI'(hw_reg[IW-1:0]);
                    rsp_next.status    = idalloc_pkg::ST_OK;
                    rsp_next.result_id = grant_wide[IDW-1:0];
                end
                else
                begin
                    rsp_next.status = idalloc_pkg::ST_FULL;
                end
            end
            idalloc_pkg::OP_FREE:
            begin
                if (slot_live)
                begin
                    free_go         = 1'b1;
                    rsp_next.status = idalloc_pkg::ST_OK;
                end
            end
            idalloc_pkg::OP_SEARCH:
            begin
                if (slot_live)
                begin
                    rsp_next.status       = idalloc_pkg::ST_OK;
                    rsp_next.result_owner = owner_wide[TW-1:0];
                end
            end
            idalloc_pkg::OP_OTHER:
            begin
                rsp_next.status = idalloc_pkg::ST_UNUSED;
            end
            default:
            begin
                rsp_next.status = idalloc_pkg::ST_UNUSED;
            end
        endcase
    end

    // Free-list head, high-water count and result register next values.
    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        hw_next         = hw_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
            if (alloc_go && alloc_from_list)
            begin
                if (rd_link_reg.last)
                begin
                    head_valid_next = 1'b0;
                end
                else
                begin
                    head_next = rd_link_reg.idx;
                end
            end
            else if (alloc_go)
            begin
                hw_next = hw_reg + 1'b1;
            end
            if (free_go)
            begin
                head_valid_next = 1'b1;
                head_next       = slot_idx;
            end
        end
    end

    // Single write port of the in-use memory.
    always_comb
    begin
        inuse_we   = exec_fire && (alloc_go || free_go);
        inuse_addr = alloc_go ? alloc_slot : slot_idx;
        inuse_din  = alloc_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= idalloc_pkg::BK_IDLE;
            head_valid_reg <= 1'b0;
            head_reg       <= '0;
            hw_reg         <= '0;
            deny_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_reg       <= head_next;
            hw_reg         <= hw_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                deny_reg <= cfg_wr_data;
            end
        end
    end

    // Operation and result payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            task_reg <= head_task;
        end
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Memory reads, registered during the read phase, which leads straight into execution.
    always_ff @(posedge clk)
    begin
        if (state_reg == idalloc_pkg::BK_READ)
        begin
            rd_inuse_reg <= inuse_mem[slot_idx];
            rd_owner_reg <= owner_mem[slot_idx];
            rd_link_reg  <= link_mem[head_reg];
        end
    end

    // Memory writes.
    always_ff @(posedge clk)
    begin
        if (inuse_we)
        begin
            inuse_mem[inuse_addr] <= inuse_din;
        end
        if (exec_fire && alloc_go)
        begin
            owner_mem[alloc_slot] <= tag_wide[OWNER_WIDTH-1:0];
        end
        if (exec_fire && free_go)
        begin
            link_mem[slot_idx] <= '{last: !head_valid_reg, idx: head_reg};
        end
    end

`ifndef SYNTHESIS
    // The read phase only ever follows taking an operation from the queue.
    a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == idalloc_pkg::BK_READ) |-> $past(pop))
        else $error("read phase entered without a queue transfer");

    // A fresh result appears only out of the execute phase.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == idalloc_pkg::BK_EXEC))
        else $error("result raised outside the execute phase");

    // A non-empty free list needs at least one slot ever handed out.
    a_head_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg |-> (CW'(head_reg) < hw_reg))
        else $error("free-list head above the high-water mark");

    // The high-water mark moves by at most one and never past the table size.
    a_hw_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hw_reg != $past(hw_reg)) |-> ((hw_reg == $past(hw_reg) + 1'b1)
            && (hw_reg <= CW'(SLOT_COUNT))))
        else $error("high-water mark moved out of step");
`endif

endmodule

`default_nettype wire

>>> src/id_allocator_free_list_core.sv
// Slot ID allocator with a LIFO free list. A request passes through the queue and then the back
// end's take / memory read / execute sequence over single-port slot memories; the back end
// finishes one operation before it takes the next, and waits in execute while a result is stalled.
// Reset clears control state only; slots at or above the high-water count read as unused, so no
// clearing pass is needed and requests are taken as soon as reset is released.
// Depends on idalloc_pkg, idalloc_front, idalloc_queue and idalloc_back.
`timescale 1ns / 1ps
`default_nettype none

module id_allocator_free_list_core #(
    parameter int SLOT_COUNT  = idalloc_pkg::SLOT_COUNT_DEF,
    parameter int OWNER_WIDTH = idalloc_pkg::OWNER_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire idalloc_pkg::req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output idalloc_pkg::rsp_t      rsp
);

    idalloc_pkg::qstat_t qstat;
    idalloc_pkg::task_t  push_task;
    idalloc_pkg::task_t  head_task;
    logic                push;
    logic                pop;

    // Request intake and classification.
    idalloc_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .push_task (push_task)
    );

    // Decoupling queue.
    idalloc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head_task (head_task),
        .qstat     (qstat)
    );

    // Execution against the slot memories.
    idalloc_back #(
        .SLOT_COUNT  (SLOT_COUNT),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_task   (head_task),
        .qstat       (qstat),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
